// File: sv/clrs_pkg.sv
package clrs_pkg;

    // Default number of record slots.
    localparam int CAPACITY_DEFAULT = 16;

    // Field widths fixed by the stream format.
    localparam int MODE_W   = 3;
    localparam int ID_W     = 24;
    localparam int AGE_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    // Position field wide enough for the largest supported capacity.
    localparam int POS_W = 8;

    // Command codes.
    localparam logic [MODE_W-1:0] MODE_INS_HEAD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_TAIL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AFTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RM_HEAD   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RM_TAIL   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RM_TARGET = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd7;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    // Operation applied to the cell row.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_kind_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [AGE_W-1:0] age;
    } record_t;

    typedef struct packed {
        cell_kind_t       kind;
        logic [POS_W-1:0] pos;
        record_t          new_rec;
        logic [ID_W-1:0]  target;
    } cell_cmd_t;

endpackage

// File: sv/clrs_cell.sv
module clrs_cell #(
    parameter int INDEX = 0
) (
    input  logic                        aclk,
    input  clrs_pkg::cell_cmd_t         cmd,
    input  clrs_pkg::record_t           left_rec,
    input  clrs_pkg::record_t           right_rec,
    output clrs_pkg::record_t           rec,
    output logic                        hit
);

    localparam logic [clrs_pkg::POS_W-1:0] MY_POS = clrs_pkg::POS_W'(INDEX);

    clrs_pkg::record_t rec_reg;
    clrs_pkg::record_t rec_next;

    // An insert opens a gap by taking the left neighbor; a delete closes it
    // by taking the right neighbor.
    always_comb begin
        rec_next = rec_reg;
        unique case (cmd.kind)
            clrs_pkg::CELL_INSERT: begin
                if (MY_POS == cmd.pos) begin
                    rec_next = cmd.new_rec;
                end else if (MY_POS > cmd.pos) begin
                    rec_next = left_rec;
                end
            end
            clrs_pkg::CELL_DELETE: begin
                if (MY_POS >= cmd.pos) begin
                    rec_next = right_rec;
                end
            end
            default: begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;
    assign hit = (rec_reg.id == cmd.target);

endmodule

// File: sv/circular_list_record_store_core.sv
// Record store that keeps a circular list of up to CAPACITY records (id and
// age) in a row of cells ordered from head to tail; inserts and removals
// shift the cells behind the affected position by one place, all in the same
// cycle. Head and tail inserts and removals, clear, and commands that fail
// at once go straight to the final step without a walk. Insert after
// target, remove target and search walk the cells from the head one position
// per cycle, stopping at the first match or after the last held record. The
// input is ready again the cycle after a command is applied, so a new command
// is taken only once the last one is through. A result waits in an output
// register, so the next command is taken while it is pending; that command
// then holds in its final step until the pending result is taken.
module circular_list_record_store_core #(
    parameter int CAPACITY = clrs_pkg::CAPACITY_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // mode[2:0], new_id[26:3], new_age[34:27], target_id[58:35], zero fill
    input  logic [clrs_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], found_id[25:2], found_age[33:26], entry_count[38:34], zero
    output logic [clrs_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [clrs_pkg::MODE_W-1:0]   mode_reg, mode_next;
    clrs_pkg::record_t             new_rec_reg, new_rec_next;
    logic [clrs_pkg::ID_W-1:0]     target_reg, target_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [IDX_W-1:0]              k_reg, k_next;
    logic                          hit_reg, hit_next;
    logic [IDX_W-1:0]              hpos_reg, hpos_next;
    logic                          m_valid_reg, m_valid_next;
    logic [clrs_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    clrs_pkg::record_t   recs [CAPACITY];
    logic [CAPACITY-1:0] hits;
    clrs_pkg::cell_cmd_t cmd;

    logic                          in_fire;
    logic                          out_free;
    logic                          full;
    logic                          needs_scan;
    logic [clrs_pkg::MODE_W-1:0]   in_mode;
    logic                          scan_last;
    logic [clrs_pkg::STATUS_W-1:0] status_c;
    logic [IDX_W-1:0]              pos_c;
    logic                          do_ins, do_del, do_clr, do_found;
    clrs_pkg::record_t             found_c;

    // Row of cells, head at cell zero.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        clrs_pkg::record_t left_rec;
        clrs_pkg::record_t right_rec;
        if (i == 0) begin : g_first
            assign left_rec = cmd.new_rec;
        end else begin : g_inner_l
            assign left_rec = recs[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_rec = recs[i];
        end else begin : g_inner_r
            assign right_rec = recs[i+1];
        end
        clrs_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .left_rec (left_rec),
            .right_rec(right_rec),
            .rec      (recs[i]),
            .hit      (hits[i])
        );
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (cnt_reg == CNT_W'(CAPACITY));
    assign in_mode  = s_tdata[2:0];
    assign scan_last = (CNT_W'(k_reg) == cnt_reg - CNT_W'(1));

    // A targeted command walks only when the list has records to look at.
    always_comb begin
        needs_scan = 1'b0;
        if (cnt_reg != '0) begin
            if (in_mode == clrs_pkg::MODE_RM_TARGET || in_mode == clrs_pkg::MODE_SEARCH) begin
                needs_scan = 1'b1;
            end else if (in_mode == clrs_pkg::MODE_INS_AFTER && !full) begin
                needs_scan = 1'b1;
            end
        end
    end

    // Decide the outcome of the command once the walk is over.
    always_comb begin
        status_c = clrs_pkg::STATUS_OK;
        pos_c    = '0;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_clr   = 1'b0;
        do_found = 1'b0;
        unique case (mode_reg)
            clrs_pkg::MODE_INS_HEAD, clrs_pkg::MODE_INS_TAIL,
            clrs_pkg::MODE_INS_AFTER: begin
                if (full) begin
                    status_c = clrs_pkg::STATUS_FULL;
                end else if (mode_reg == clrs_pkg::MODE_INS_AFTER && cnt_reg != '0
                             && !hit_reg) begin
                    status_c = clrs_pkg::STATUS_NOT_FOUND;
                end else begin
                    do_ins = 1'b1;
                    if (cnt_reg == '0 || mode_reg == clrs_pkg::MODE_INS_HEAD) begin
                        pos_c = '0;
                    end else if (mode_reg == clrs_pkg::MODE_INS_TAIL) begin
                        pos_c = IDX_W'(cnt_reg);
                    end else begin
                        pos_c = IDX_W'(hpos_reg + IDX_W'(1));
                    end
                end
            end
            clrs_pkg::MODE_CLEAR: begin
                if (cnt_reg == '0) begin
                    status_c = clrs_pkg::STATUS_EMPTY;
                end else begin
                    do_clr = 1'b1;
                end
            end
            default: begin
                if (cnt_reg == '0) begin
                    status_c = clrs_pkg::STATUS_EMPTY;
                end else if (mode_reg == clrs_pkg::MODE_RM_HEAD) begin
                    do_found = 1'b1;
                    pos_c    = '0;
                end else if (mode_reg == clrs_pkg::MODE_RM_TAIL) begin
                    do_found = 1'b1;
                    pos_c    = IDX_W'(cnt_reg - CNT_W'(1));
                end else if (hit_reg) begin
                    do_found = 1'b1;
                    pos_c    = hpos_reg;
                end else begin
                    status_c = clrs_pkg::STATUS_NOT_FOUND;
                end
                do_del = do_found && (mode_reg != clrs_pkg::MODE_SEARCH);
            end
        endcase
        found_c = recs[pos_c];
    end

    // Command to the cell row; it changes the cells only in the final cycle.
    always_comb begin
        cmd.kind    = clrs_pkg::CELL_HOLD;
        cmd.pos     = clrs_pkg::POS_W'(pos_c);
        cmd.new_rec = new_rec_reg;
        cmd.target  = target_reg;
        if (state_reg == ST_DONE && out_free) begin
            if (do_ins) begin
                cmd.kind = clrs_pkg::CELL_INSERT;
            end else if (do_del) begin
                cmd.kind = clrs_pkg::CELL_DELETE;
            end
        end
    end

    // Sequencer: take a command, walk if needed, then apply and report.
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        new_rec_next = new_rec_reg;
        target_next  = target_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        hit_next     = hit_reg;
        hpos_next    = hpos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    mode_next       = in_mode;
                    new_rec_next.id  = s_tdata[26:3];
                    new_rec_next.age = s_tdata[34:27];
                    target_next     = s_tdata[58:35];
                    k_next          = '0;
                    hit_next        = 1'b0;
                    hpos_next       = '0;
                    state_next      = needs_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (hits[k_reg]) begin
                    hit_next   = 1'b1;
                    hpos_next  = k_reg;
                    state_next = ST_DONE;
                end else if (scan_last) begin
                    state_next = ST_DONE;
                end else begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (do_ins) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end else if (do_del) begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end else if (do_clr) begin
                        cnt_next = '0;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[1:0] = status_c;
                    if (do_found) begin
                        m_data_next[25:2]  = found_c.id;
                        m_data_next[33:26] = found_c.age;
                    end
                    if (do_ins) begin
                        m_data_next[38:34] = clrs_pkg::COUNT_W'(cnt_reg + CNT_W'(1));
                    end else if (do_del) begin
                        m_data_next[38:34] = clrs_pkg::COUNT_W'(cnt_reg - CNT_W'(1));
                    end else if (do_clr) begin
                        m_data_next[38:34] = '0;
                    end else begin
                        m_data_next[38:34] = clrs_pkg::COUNT_W'(cnt_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state is reset; command and result payload are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg    <= mode_next;
        new_rec_reg <= new_rec_next;
        target_reg  <= target_next;
        k_reg       <= k_next;
        hit_reg     <= hit_next;
        hpos_reg    <= hpos_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    // The record count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("record count above capacity");

    // The walk stays inside the held records.
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> CNT_W'(k_reg) < cnt_reg)
        else $error("walk beyond held records");

    // A full status is reported only when every slot is taken.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free && status_c == clrs_pkg::STATUS_FULL)
        |=> cnt_reg == CNT_W'(CAPACITY))
        else $error("full status with free slots");

    // An empty status leaves the list empty.
    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free && status_c == clrs_pkg::STATUS_EMPTY)
        |=> cnt_reg == '0)
        else $error("empty status with records held");
`endif

endmodule
